// ----- hdl/jdms_pkg.sv -----
package jdms_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLIPPER_ANGLE = 2'd2;

	localparam logic [6:0] DEAD_ZONE_RST = 7'd15;
	localparam logic [15:0] DEBOUNCE_RST = 16'd150;
	localparam logic [6:0] FLIPPER_ANGLE_RST = 7'd75;

	localparam logic [7:0] SERVO_CENTER = 8'd90;
	localparam logic [7:0] SERVO_MAX = 8'd180;
	localparam logic [7:0] DUTY_MAX = 8'd255;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD = 2'd1;
	localparam logic [1:0] DIR_REV = 2'd2;

	typedef struct packed {
		logic link_up;
		logic stop_button;
		logic safety_button;
		logic flip_button;
		logic drum_button;
		logic signed [7:0] stick_x;
		logic signed [7:0] stick_y;
		logic [31:0] time_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0] left_dir;
		logic [7:0] left_duty;
		logic [1:0] right_dir;
		logic [7:0] right_duty;
		logic drum_run;
		logic [7:0] servo_left_deg;
		logic [7:0] servo_right_deg;
		logic led_on;
		logic stop_latched;
		logic safe_mode;
	} out_item_t;

endpackage

// ----- hdl/jdms_if.sv -----
interface jdms_in_if;
	logic valid;
	logic ready;
	jdms_pkg::in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface jdms_out_if;
	logic valid;
	logic ready;
	jdms_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface jdms_cfg_if;
	logic valid;
	logic ready;
	logic [jdms_pkg::CFG_IDX_W-1:0] index;
	logic [jdms_pkg::CFG_DATA_W-1:0] wdata;

	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface

// ----- hdl/joystick_drive_mixer_with_safety_unit.sv -----
// Every poll but an active diagonal one goes from idle straight to the done state; a diagonal
// first passes through two squaring steps, 12 square-root steps and two scaling steps.
// A new poll is taken only in the idle state; the diagonal steps all use the single
// 12x12 multiplier that the sequencer reuses for squares, root trials and duty scaling.
// A finished result waits in the output register while the next poll is taken.
// Reset (arst_n low): safety engaged, e-stop clear, toggles off, servos at 90, registers default.
module joystick_drive_mixer_with_safety_unit (
	input logic clk,
	input logic arst_n,
	jdms_in_if.sink drive_in,
	jdms_out_if.source drive_out,
	jdms_cfg_if.sink cfg
);
	import jdms_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_SCL,
		ST_SCR,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [6:0] dz_q;
	logic [15:0] db_q;
	logic [6:0] fa_q;

	logic was_linked_q, estop_q, safety_q, drum_q, flipper_q, led_q;
	logic [31:0] flip_t_q, drum_t_q;
	logic [7:0] servo_l_q, servo_r_q;

	out_item_t res_q;
	logic [7:0] ax_q, ay_q;
	logic [15:0] sum_q;
	logic [11:0] root_q;
	logic [3:0] cnt_q;

	// next values computed from the incoming beat
	in_item_t d;
	logic [7:0] ax, ay;
	logic cx, cy, flip_ok, drum_ok, go_diag, safe_a, safe_b;
	logic nx_linked, nx_estop, nx_safety, nx_drum, nx_flipper, nx_led;
	logic [31:0] nx_flip_t, nx_drum_t;
	logic [7:0] nx_servo_l, nx_servo_r, hi_deg;
	out_item_t res_n;

	// shared multiplier
	logic [11:0] mul_a, mul_b, trial;
	logic [23:0] prod;
	logic [7:0] scaled;

	logic out_load;

	function automatic logic [7:0] map_axis(input logic [7:0] a);
		logic [15:0] w;
		w = {a, 8'd0} - {8'd0, a};
		return w[14:7];
	endfunction

	assign drive_in.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_load = (state_q == ST_DONE) && (!drive_out.valid || drive_out.ready);

	always_comb begin
		d = drive_in.data;
		ax = d.stick_x[7] ? (8'd0 - d.stick_x) : d.stick_x;
		ay = d.stick_y[7] ? (8'd0 - d.stick_y) : d.stick_y;
		cx = (ax < {1'b0, dz_q});
		cy = (ay < {1'b0, dz_q});
		flip_ok = d.flip_button && ((d.time_ms - flip_t_q) > {16'd0, db_q});
		drum_ok = d.drum_button && ((d.time_ms - drum_t_q) > {16'd0, db_q});
		hi_deg = SERVO_CENTER + {1'b0, fa_q};
		safe_a = was_linked_q ? safety_q : 1'b1;
		safe_b = safe_a ^ d.safety_button;

		nx_linked = was_linked_q;
		nx_estop = estop_q;
		nx_safety = safety_q;
		nx_drum = drum_q;
		nx_flipper = flipper_q;
		nx_led = led_q;
		nx_flip_t = flip_t_q;
		nx_drum_t = drum_t_q;
		nx_servo_l = servo_l_q;
		nx_servo_r = servo_r_q;
		go_diag = 1'b0;

		res_n.left_dir = DIR_STOP;
		res_n.left_duty = 8'd0;
		res_n.right_dir = DIR_STOP;
		res_n.right_duty = 8'd0;
		res_n.drum_run = 1'b0;

		if (!d.link_up) begin
			nx_linked = 1'b0;
		end else begin
			nx_linked = 1'b1;
			nx_safety = safe_a;
			if (d.stop_button || estop_q) begin
				nx_estop = 1'b1;
				nx_safety = 1'b1;
			end else begin
				nx_safety = safe_b;
				if (safe_b) begin
					nx_led = 1'b1;
				end else begin
					if (flip_ok) begin
						nx_flipper = ~flipper_q;
						nx_flip_t = d.time_ms;
					end
					if (drum_ok) begin
						nx_drum = ~drum_q;
						nx_drum_t = d.time_ms;
					end
					if (cx && cy) begin
						res_n.left_dir = DIR_STOP;
						res_n.right_dir = DIR_STOP;
					end else if (cy) begin
						res_n.left_dir = (d.stick_x > 0) ? DIR_FWD : DIR_REV;
						res_n.right_dir = (d.stick_x > 0) ? DIR_REV : DIR_FWD;
						res_n.left_duty = map_axis(ax);
						res_n.right_duty = map_axis(ax);
					end else if (cx) begin
						res_n.left_dir = d.stick_y[7] ? DIR_REV : DIR_FWD;
						res_n.right_dir = d.stick_y[7] ? DIR_REV : DIR_FWD;
						res_n.left_duty = map_axis(ay);
						res_n.right_duty = map_axis(ay);
					end else begin
						// duties here are pre-scale; the sequencer scales them by the magnitude
						go_diag = 1'b1;
						res_n.left_dir = (d.stick_y > 0) ? DIR_FWD : DIR_REV;
						res_n.right_dir = (d.stick_y > 0) ? DIR_FWD : DIR_REV;
						res_n.left_duty = (d.stick_x > 0) ? DUTY_MAX : map_axis(ay);
						res_n.right_duty = (d.stick_x > 0) ? map_axis(ay) : DUTY_MAX;
					end
					res_n.drum_run = nx_drum;
					if (nx_flipper) begin
						nx_servo_l = (hi_deg > SERVO_MAX) ? SERVO_MAX : hi_deg;
						nx_servo_r = ({1'b0, fa_q} > SERVO_CENTER) ? 8'd0
							: (SERVO_CENTER - {1'b0, fa_q});
					end else begin
						nx_servo_l = SERVO_CENTER;
						nx_servo_r = SERVO_CENTER;
					end
					nx_led = 1'b0;
				end
			end
		end

		res_n.servo_left_deg = nx_servo_l;
		res_n.servo_right_deg = nx_servo_r;
		res_n.led_on = nx_led;
		res_n.stop_latched = nx_estop;
		res_n.safe_mode = nx_safety;
	end

	always_comb begin
		trial = root_q | (12'd1 << cnt_q);
		case (state_q)
			ST_SQX: begin
				mul_a = {4'd0, ax_q};
				mul_b = {4'd0, ax_q};
			end
			ST_SQY: begin
				mul_a = {4'd0, ay_q};
				mul_b = {4'd0, ay_q};
			end
			ST_ROOT: begin
				mul_a = trial;
				mul_b = trial;
			end
			ST_SCL: begin
				mul_a = {4'd0, res_q.left_duty};
				mul_b = root_q;
			end
			ST_SCR: begin
				mul_a = {4'd0, res_q.right_duty};
				mul_b = root_q;
			end
			default: begin
				mul_a = 12'd0;
				mul_b = 12'd0;
			end
		endcase
		prod = mul_a * mul_b;
		// duty * s / 2048, saturate at full duty
		scaled = (prod[23:19] != 5'd0) ? DUTY_MAX : prod[18:11];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dz_q <= DEAD_ZONE_RST;
			db_q <= DEBOUNCE_RST;
			fa_q <= FLIPPER_ANGLE_RST;
			was_linked_q <= 1'b0;
			estop_q <= 1'b0;
			safety_q <= 1'b1;
			drum_q <= 1'b0;
			flipper_q <= 1'b0;
			led_q <= 1'b0;
			flip_t_q <= 32'd0;
			drum_t_q <= 32'd0;
			servo_l_q <= SERVO_CENTER;
			servo_r_q <= SERVO_CENTER;
			res_q <= '0;
			ax_q <= 8'd0;
			ay_q <= 8'd0;
			sum_q <= 16'd0;
			root_q <= 12'd0;
			cnt_q <= 4'd0;
			drive_out.valid <= 1'b0;
			drive_out.data <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_DEAD_ZONE: dz_q <= cfg.wdata[6:0];
					CFG_DEBOUNCE_MS: db_q <= cfg.wdata;
					CFG_FLIPPER_ANGLE: fa_q <= cfg.wdata[6:0];
					default: ;
				endcase
			end

			// load the finished result, or drop the beat once taken
			if (out_load) begin
				drive_out.valid <= 1'b1;
				drive_out.data <= res_q;
			end else if (drive_out.valid && drive_out.ready) begin
				drive_out.valid <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (drive_in.valid) begin
						was_linked_q <= nx_linked;
						estop_q <= nx_estop;
						safety_q <= nx_safety;
						drum_q <= nx_drum;
						flipper_q <= nx_flipper;
						led_q <= nx_led;
						flip_t_q <= nx_flip_t;
						drum_t_q <= nx_drum_t;
						servo_l_q <= nx_servo_l;
						servo_r_q <= nx_servo_r;
						res_q <= res_n;
						ax_q <= ax;
						ay_q <= ay;
						state_q <= go_diag ? ST_SQX : ST_DONE;
					end
				end
				ST_SQX: begin
					sum_q <= prod[15:0];
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					sum_q <= sum_q + prod[15:0];
					root_q <= 12'd0;
					cnt_q <= 4'd11;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					// keep the trial bit while its square does not exceed (x^2 + y^2) * 256
					if (prod <= {sum_q, 8'd0}) begin
						root_q <= trial;
					end
					if (cnt_q == 4'd0) begin
						state_q <= ST_SCL;
					end else begin
						cnt_q <= cnt_q - 4'd1;
					end
				end
				ST_SCL: begin
					res_q.left_duty <= scaled;
					state_q <= ST_SCR;
				end
				ST_SCR: begin
					res_q.right_duty <= scaled;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- tb/joystick_drive_mixer_with_safety_unit_test.sv -----
module joystick_drive_mixer_with_safety_unit_test;
	import jdms_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	jdms_in_if drive_in_ch();
	jdms_out_if drive_out_ch();
	jdms_cfg_if cfg_ch();

	joystick_drive_mixer_with_safety_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.drive_in(drive_in_ch),
		.drive_out(drive_out_ch),
		.cfg(cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted robot state and register copies
	logic [6:0] zone_limit;
	logic [15:0] debounce_limit;
	logic [6:0] flip_angle;
	bit linked_seen, estop_held, safety_on, drum_on, flipper_up, led_lit;
	logic [31:0] flip_stamp, drum_stamp;
	logic [7:0] servo_l, servo_r;

	out_item_t drive_expect_q[$];
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	int unsigned holdoff_reqs = 0;
	int unsigned holdoff_served = 0;
	logic [31:0] now_ms = '0;
	bit allow_stop = 1'b0;

	task automatic reset_drive_model();
		zone_limit = DEAD_ZONE_RST;
		debounce_limit = DEBOUNCE_RST;
		flip_angle = FLIPPER_ANGLE_RST;
		linked_seen = 1'b0;
		estop_held = 1'b0;
		safety_on = 1'b1;
		drum_on = 1'b0;
		flipper_up = 1'b0;
		led_lit = 1'b0;
		flip_stamp = '0;
		drum_stamp = '0;
		servo_l = SERVO_CENTER;
		servo_r = SERVO_CENTER;
	endtask

	function automatic int unsigned stick_to_duty(int unsigned a);
		return (a * 255) / 128;
	endfunction

	function automatic int unsigned scale_by_root(int unsigned d, int unsigned root);
		int unsigned v;
		v = (d * root) >> 11;
		return (v > 255) ? 255 : v;
	endfunction

	function automatic out_item_t predict_drive(in_item_t p);
		out_item_t r;
		int sx, sy, hi;
		int unsigned ax, ay, sq, root, trial, l_duty, r_duty;
		bit cx, cy;
		r = '0;
		r.left_dir = DIR_STOP;
		r.right_dir = DIR_STOP;
		if (!p.link_up) begin
			linked_seen = 1'b0;
		end else begin
			if (!linked_seen) begin
				safety_on = 1'b1;
				linked_seen = 1'b1;
			end
			if (p.stop_button || estop_held) begin
				estop_held = 1'b1;
				safety_on = 1'b1;
			end else begin
				if (p.safety_button)
					safety_on = !safety_on;
				if (safety_on) begin
					led_lit = 1'b1;
				end else begin
					sx = $signed(p.stick_x);
					sy = $signed(p.stick_y);
					ax = (sx < 0) ? -sx : sx;
					ay = (sy < 0) ? -sy : sy;
					cx = ax < zone_limit;
					cy = ay < zone_limit;
					if (p.flip_button && (p.time_ms - flip_stamp) > debounce_limit) begin
						flipper_up = !flipper_up;
						flip_stamp = p.time_ms;
					end
					if (p.drum_button && (p.time_ms - drum_stamp) > debounce_limit) begin
						drum_on = !drum_on;
						drum_stamp = p.time_ms;
					end
					if (cx && cy) begin
						r.left_dir = DIR_STOP;
						r.right_dir = DIR_STOP;
					end else if (cy) begin
						// spin in place; x is never 0 here, since this branch needs a nonzero dead zone
						r.left_dir = (sx > 0) ? DIR_FWD : DIR_REV;
						r.right_dir = (sx > 0) ? DIR_REV : DIR_FWD;
						r.left_duty = 8'(stick_to_duty(ax));
						r.right_duty = 8'(stick_to_duty(ax));
					end else if (cx) begin
						r.left_dir = (sy < 0) ? DIR_REV : DIR_FWD;
						r.right_dir = r.left_dir;
						r.left_duty = 8'(stick_to_duty(ay));
						r.right_duty = 8'(stick_to_duty(ay));
					end else begin
						// magnitude with 4 fraction bits: largest root with root^2 <= 256*(x^2+y^2)
						sq = (ax * ax + ay * ay) << 8;
						root = 0;
						for (int b = 12; b >= 0; b--) begin
							trial = root | (1 << b);
							if (trial * trial <= sq)
								root = trial;
						end
						r.left_dir = (sy > 0) ? DIR_FWD : DIR_REV;
						r.right_dir = r.left_dir;
						if (sx > 0) begin
							l_duty = 255;
							r_duty = stick_to_duty(ay);
						end else begin
							r_duty = 255;
							l_duty = stick_to_duty(ay);
						end
						r.left_duty = 8'(scale_by_root(l_duty, root));
						r.right_duty = 8'(scale_by_root(r_duty, root));
					end
					r.drum_run = drum_on;
					if (flipper_up) begin
						hi = 90 + flip_angle;
						servo_l = (hi > 180) ? SERVO_MAX : 8'(hi);
						servo_r = (flip_angle > 90) ? 8'd0 : 8'(90 - flip_angle);
					end else begin
						servo_l = SERVO_CENTER;
						servo_r = SERVO_CENTER;
					end
					led_lit = 1'b0;
				end
			end
		end
		r.servo_left_deg = servo_l;
		r.servo_right_deg = servo_r;
		r.led_on = led_lit;
		r.stop_latched = estop_held;
		r.safe_mode = safety_on;
		return r;
	endfunction

	function automatic logic [7:0] rand_axis(bit near);
		int v;
		if (near) begin
			v = int'($urandom_range(0, 2 * zone_limit + 2)) - int'(zone_limit) - 1;
		end else begin
			case ($urandom_range(0, 11))
				0: v = -128;
				1: v = 127;
				2: v = -127;
				3: v = 0;
				4: v = int'(zone_limit);
				5: v = -int'(zone_limit);
				default: v = int'($urandom_range(0, 255));
			endcase
		end
		return v[7:0];
	endfunction

	function automatic in_item_t random_poll();
		in_item_t p;
		int unsigned shape;
		p = '0;
		p.link_up = ($urandom_range(0, 29) != 0);
		// a stop press with the link up latches for good, so hold it back until the end
		if (allow_stop)
			p.stop_button = ($urandom_range(0, 1) != 0);
		else
			p.stop_button = !p.link_up && ($urandom_range(0, 1) != 0);
		p.safety_button = safety_on ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 24) == 0);
		p.flip_button = ($urandom_range(0, 4) == 0);
		p.drum_button = ($urandom_range(0, 4) == 0);
		shape = $urandom_range(0, 9);
		p.stick_x = rand_axis(shape == 0 || shape == 2);
		p.stick_y = rand_axis(shape == 0 || shape == 1);
		case ($urandom_range(0, 19))
			0: now_ms = $urandom();
			1, 2: now_ms += $urandom_range(0, 70000);
			default: now_ms += $urandom_range(0, 300);
		endcase
		p.time_ms = now_ms;
		return p;
	endfunction

	// offer one poll; keep valid high into the next beat unless a gap follows
	task automatic send_poll(input in_item_t p);
		int unsigned gap;
		drive_in_ch.valid <= 1'b1;
		drive_in_ch.data <= p;
		do @(posedge clk); while (!drive_in_ch.ready);
		drive_expect_q.push_back(predict_drive(p));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				drive_in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic poll(bit link, bit stop, bit safe, bit flip, bit drum, int x, int y,
			logic [31:0] t);
		in_item_t p;
		p.link_up = link;
		p.stop_button = stop;
		p.safety_button = safe;
		p.flip_button = flip;
		p.drum_button = drum;
		p.stick_x = x[7:0];
		p.stick_y = y[7:0];
		p.time_ms = t;
		now_ms = t;
		send_poll(p);
	endtask

	task automatic settle();
		drive_in_ch.valid <= 1'b0;
		while (drive_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_DEAD_ZONE: zone_limit = 7'(val);
			CFG_DEBOUNCE_MS: debounce_limit = 16'(val);
			default: flip_angle = 7'(val);
		endcase
	endtask

	task automatic set_config(int unsigned dz, int unsigned deb, int unsigned ang);
		write_reg(CFG_DEAD_ZONE, dz);
		write_reg(CFG_DEBOUNCE_MS, deb);
		write_reg(CFG_FLIPPER_ANGLE, ang);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_link_and_safety();
		poll(0, 0, 0, 0, 0, 0, 0, 32'd10);
		poll(0, 1, 1, 1, 1, -128, 127, 32'd20);
		poll(1, 0, 0, 1, 1, 100, 100, 32'd30);
		poll(1, 0, 1, 0, 0, 0, 0, 32'd40);
	endtask

	task automatic test_stick_extremes();
		poll(1, 0, 0, 0, 0, 127, 0, 32'd50);
		poll(1, 0, 0, 0, 0, -128, 0, 32'd50);
		poll(1, 0, 0, 0, 0, 0, 127, 32'd50);
		poll(1, 0, 0, 0, 0, 0, -128, 32'd50);
		poll(1, 0, 0, 0, 0, 127, 127, 32'd50);
		poll(1, 0, 0, 0, 0, -128, -128, 32'd50);
		poll(1, 0, 0, 0, 0, 127, -128, 32'd50);
		poll(1, 0, 0, 0, 0, -128, 127, 32'd50);
		poll(1, 0, 0, 0, 0, 14, -14, 32'd50);
		poll(1, 0, 0, 0, 0, 15, 15, 32'd50);
		poll(1, 0, 0, 0, 0, -15, 14, 32'd50);
		poll(1, 0, 0, 0, 0, 0, -15, 32'd50);
	endtask

	task automatic test_toggles_and_debounce();
		poll(1, 0, 0, 1, 0, 20, 0, 32'd1000);
		poll(1, 0, 0, 1, 0, 20, 0, 32'd1100);
		// exactly the debounce window apart: flip rejected, drum accepted
		poll(1, 0, 0, 1, 1, 0, 40, 32'd1150);
		poll(1, 0, 0, 1, 1, 0, 40, 32'd1151);
		poll(1, 0, 0, 1, 1, -60, 60, 32'hFFFF_FFF0);
		// across the time wrap
		poll(1, 0, 0, 1, 1, -60, -60, 32'h0000_0090);
		poll(1, 0, 1, 0, 0, 90, 90, 32'h0000_0100);
		poll(0, 0, 0, 0, 0, 90, 90, 32'h0000_0110);
	endtask

	task automatic test_config_phase(int unsigned dz, int unsigned deb, int unsigned ang,
			int unsigned n);
		settle();
		set_config(dz, deb, ang);
		repeat (n) send_poll(random_poll());
	endtask

	task automatic test_backpressure();
		holdoff_reqs <= holdoff_reqs + 1;
		repeat (40) send_poll(random_poll());
	endtask

	task automatic test_estop();
		allow_stop = 1'b1;
		poll(1, 1, 0, 0, 0, 127, 127, now_ms);
		repeat (40) send_poll(random_poll());
	endtask

	// receiver: shifting stall patterns plus a requested long hold-off
	initial begin
		int unsigned pattern_left, mode, hold_left;
		pattern_left = 0;
		mode = 0;
		hold_left = 0;
		drive_out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_served != holdoff_reqs) begin
				hold_left = 400;
				holdoff_served = holdoff_reqs;
			end
			if (pattern_left == 0) begin
				mode = $urandom_range(0, 3);
				pattern_left = $urandom_range(16, 96);
			end
			pattern_left--;
			if (hold_left != 0) begin
				hold_left--;
				drive_out_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: drive_out_ch.ready <= 1'b1;
					1: drive_out_ch.ready <= ($urandom_range(0, 1) != 0);
					2: drive_out_ch.ready <= ($urandom_range(0, 3) == 0);
					default: drive_out_ch.ready <= (pattern_left % 3 != 0);
				endcase
			end
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// sample at the falling edge; a beat seen here completes at the next rising edge
	always @(negedge clk) begin
		out_item_t want, got;
		if (arst_n && drive_out_ch.valid && drive_out_ch.ready) begin
			got = drive_out_ch.data;
			if (drive_expect_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
			end else begin
				want = drive_expect_q.pop_front();
				check_field("left_dir", 32'(want.left_dir), 32'(got.left_dir));
				check_field("left_duty", 32'(want.left_duty), 32'(got.left_duty));
				check_field("right_dir", 32'(want.right_dir), 32'(got.right_dir));
				check_field("right_duty", 32'(want.right_duty), 32'(got.right_duty));
				check_field("drum_run", 32'(want.drum_run), 32'(got.drum_run));
				check_field("servo_left_deg", 32'(want.servo_left_deg),
					32'(got.servo_left_deg));
				check_field("servo_right_deg", 32'(want.servo_right_deg),
					32'(got.servo_right_deg));
				check_field("led_on", 32'(want.led_on), 32'(got.led_on));
				check_field("stop_latched", 32'(want.stop_latched), 32'(got.stop_latched));
				check_field("safe_mode", 32'(want.safe_mode), 32'(got.safe_mode));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		drive_in_ch.valid <= 1'b0;
		drive_in_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_DEAD_ZONE;
		cfg_ch.wdata <= '0;
		reset_drive_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_link_and_safety();
		test_stick_extremes();
		test_toggles_and_debounce();
		test_config_phase(15, 150, 75, 220);
		test_config_phase(0, 0, 0, 220);
		test_config_phase(127, 65535, 89, 220);
		test_config_phase(1, 1, 127, 150);
		test_config_phase($urandom_range(0, 127), $urandom_range(0, 65535),
			$urandom_range(0, 89), 220);
		test_backpressure();
		test_estop();

		settle();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
